/* rtl/swrl_pkg.sv */
package swrl_pkg;

  localparam int RING_DEPTH_DEF = 16;
  localparam int STAMP_BITS_DEF = 32;
  localparam int STAMP_MAX_BITS = 64;

  localparam int TIME_BITS     = 32;
  localparam int WINDOW_BITS   = 32;
  localparam int ALLOWED_BITS  = 5;
  localparam int OCC_BITS      = 5;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [ALLOWED_BITS-1:0] ALLOWED_RESET = 5'd3;
  localparam logic [WINDOW_BITS-1:0]  WINDOW_RESET  = 32'd10;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ALLOWED_CALLS = 2'd0,
    CFG_WINDOW_TICKS  = 2'd1
  } cfg_reg_e;

endpackage

/* rtl/sliding_window_rate_limiter.sv */
// Sliding-window log rate limiter. A request is taken when start_i is high
// while busy_o is low, and one result (granted_o, occupancy_o) appears for a
// single cycle with done_o high; the receiver cannot stall it, so it must
// capture the result on that cycle. The timestamps of granted requests are held
// in a ring memory with a registered read port; expiry walks the ring from the
// head one entry per cycle, dropping expired entries until one is still inside
// the window or the ring is empty, and then the grant decision is made (an empty
// ring goes straight to it). A new request may be started in the cycle where
// done_o is high. Configuration writes are taken while busy_o is low.
module sliding_window_rate_limiter #(
  parameter int RING_DEPTH = swrl_pkg::RING_DEPTH_DEF,
  parameter int STAMP_BITS = swrl_pkg::STAMP_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [swrl_pkg::TIME_BITS-1:0]     request_time_i,
  output logic                               done_o,
  output logic                               granted_o,
  output logic [swrl_pkg::OCC_BITS-1:0]      occupancy_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [swrl_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [swrl_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);
  import swrl_pkg::*;

  localparam int IdxW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CntW = $clog2(RING_DEPTH + 1);
  localparam int SumW = CntW + 1;
  localparam int LimW = (CntW > ALLOWED_BITS) ? CntW : ALLOWED_BITS;

  typedef logic [STAMP_BITS-1:0] stamp_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_CHECK  = 3'b010,
    ST_DECIDE = 3'b100
  } state_e;

  state_e                  state_q, state_d;
  logic [IdxW-1:0]         head_q, head_d;
  logic [CntW-1:0]         count_q, count_d;
  stamp_t                  now_q, now_d;
  logic [ALLOWED_BITS-1:0] allowed_q;
  logic [WINDOW_BITS-1:0]  window_q;
  logic                    done_q, done_d;
  logic                    granted_q, granted_d;
  logic [OCC_BITS-1:0]     occ_q, occ_d;

  stamp_t                  ring [RING_DEPTH];
  stamp_t                  rd_data_q;
  logic                    rd_en;
  logic [IdxW-1:0]         rd_addr;
  logic                    wr_en;
  logic [IdxW-1:0]         wr_addr;

  logic [STAMP_MAX_BITS-1:0] time_ext;
  logic [STAMP_MAX_BITS-1:0] window_ext;
  stamp_t                    win;
  stamp_t                    age;
  logic [IdxW-1:0]           head_inc;
  logic [SumW-1:0]           tail_sum;
  logic [SumW-1:0]           tail_wrap;
  logic [LimW-1:0]           allowed_ext;
  logic [LimW-1:0]           limit;

  assign time_ext    = STAMP_MAX_BITS'(request_time_i);
  assign window_ext  = STAMP_MAX_BITS'(window_q);
  assign win         = window_ext[STAMP_BITS-1:0];
  assign age         = now_q - rd_data_q;
  assign head_inc    = (head_q == IdxW'(RING_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_sum    = SumW'(head_q) + SumW'(count_q);
  assign tail_wrap   = (tail_sum >= SumW'(RING_DEPTH)) ? tail_sum - SumW'(RING_DEPTH)
                                                       : tail_sum;
  assign wr_addr     = tail_wrap[IdxW-1:0];
  assign allowed_ext = LimW'(allowed_q);
  assign limit       = (allowed_ext > LimW'(RING_DEPTH)) ? LimW'(RING_DEPTH) : allowed_ext;

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    now_d     = now_q;
    done_d    = 1'b0;
    granted_d = granted_q;
    occ_d     = occ_q;
    rd_en     = 1'b0;
    rd_addr   = head_q;
    wr_en     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          now_d = time_ext[STAMP_BITS-1:0];
          if (count_q == '0) begin
            state_d = ST_DECIDE;
          end else begin
            rd_en   = 1'b1;
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (age >= win) begin
          head_d  = head_inc;
          count_d = count_q - 1'b1;
          if (count_q != CntW'(1)) begin
            rd_en   = 1'b1;
            rd_addr = head_inc;
          end else begin
            state_d = ST_DECIDE;
          end
        end else begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        granted_d = 1'b0;
        if (LimW'(count_q) < limit) begin
          wr_en     = 1'b1;
          count_d   = count_q + 1'b1;
          granted_d = 1'b1;
        end
        occ_d   = OCC_BITS'(count_d);
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q     <= now_d;
    granted_q <= granted_d;
    occ_q     <= occ_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allowed_q <= ALLOWED_RESET;
      window_q  <= WINDOW_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ALLOWED_CALLS: allowed_q <= cfg_data_i[ALLOWED_BITS-1:0];
        CFG_WINDOW_TICKS:  window_q  <= cfg_data_i[WINDOW_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring[wr_addr] <= now_q;
    end
    if (rd_en) begin
      rd_data_q <= ring[rd_addr];
    end
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign done_o      = done_q;
  assign granted_o   = granted_q;
  assign occupancy_o = occ_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == ST_DECIDE))
    else $error("Result strobe without a decision cycle.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(RING_DEPTH))
    else $error("Ring occupancy exceeds the ring depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && granted_q) |-> (count_q != '0))
    else $error("Granted request left the ring empty.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("Accepted request did not raise busy.");

endmodule
